FILE: design/bel_pkg.sv
// ----------------------------------------------------------------------------
// bel_pkg
// Types and constants shared by the button event latch with auto-repeat.
// ----------------------------------------------------------------------------
package bel_pkg;

  localparam int NUM_BUTTONS    = 3;
  localparam int PERIOD_W       = 8;
  localparam int CNT_W          = 8;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(5);
  localparam logic [PERIOD_W-1:0] MIN_PERIOD     = PERIOD_W'(1);

  // index of the button whose repeats shorten the period
  localparam int PERIOD_BTN = 2;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_READ = 1'b1
  } req_type_t;

  typedef enum logic [0:0] {
    REG_INITIAL_REPEAT_PERIOD = 1'b0
  } reg_index_t;

  typedef struct packed {
    req_type_t  req_type;
    logic [2:0] button_levels;
  } bel_in_t;

  typedef struct packed {
    logic b1_pressed;
    logic b1_released;
    logic b1_autorep;
    logic b2_pressed;
    logic b2_released;
    logic b2_autorep;
    logic b3_pressed;
    logic b3_released;
    logic b3_autorep;
    logic one_and_three_held;
    logic one_and_three_free;
  } bel_out_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic rpt;
    logic held;
  } bel_btn_status_t;

endpackage

FILE: design/bel_btn.sv
// ----------------------------------------------------------------------------
// bel_btn
// Edge latches and auto-repeat counter for one button.
// ----------------------------------------------------------------------------
module bel_btn (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic                          read,
  input  logic                          level,
  input  logic [bel_pkg::PERIOD_W-1:0]  period,
  output bel_pkg::bel_btn_status_t      status
);
  import bel_pkg::*;

  logic             last, last_next;
  logic             pl, pl_next;
  logic             rl, rl_next;
  logic             rep, rep_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             now;
  logic             pl_t, rl_t;

  assign now  = ~level;
  assign pl_t = pl | (now & ~last);
  assign rl_t = rl | (~now & last);

  always_comb begin
    last_next = last;
    pl_next   = pl;
    rl_next   = rl;
    rep_next  = rep;
    cnt_next  = cnt;
    if (tick) begin
      last_next = now;
      pl_next   = pl_t;
      rl_next   = rl_t;
      if (pl_t) begin
        if (rl_t) begin
          cnt_next = '0;
        end else if (cnt >= period) begin
          rep_next = 1'b1;
          cnt_next = CNT_W'(1);
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
    end else if (read) begin
      rep_next = 1'b0;
      if (rl) begin
        pl_next  = 1'b0;
        rl_next  = 1'b0;
        cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
      pl   <= 1'b0;
      rl   <= 1'b0;
      rep  <= 1'b0;
      cnt  <= '0;
    end else begin
      last <= last_next;
      pl   <= pl_next;
      rl   <= rl_next;
      rep  <= rep_next;
      cnt  <= cnt_next;
    end
  end

  assign status = '{pressed: pl, released: rl, rpt: rep, held: last};

endmodule

FILE: design/button_event_latch_autorepeat.sv
// ----------------------------------------------------------------------------
// button_event_latch_autorepeat
// Three-button press/release latch with auto-repeat and a read-and-clear port.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle: a tick updates the per-button latches and
// repeat counters in the cycle it is accepted and gives no result; a read
// reports the latches, clears repeat flags and released buttons' latches and
// loads the output register in the same cycle, so its result is offered on the
// next cycle. The output register is the only thing that can hold off input,
// and only while its result waits to be taken. The repeat period is loaded from
// register 0 (byte address 0) when button three's release is read, and each
// read repeat on button three shortens it by one down to a minimum of one.
module button_event_latch_autorepeat (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bel_pkg::bel_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bel_pkg::bel_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bel_pkg::PADDR_W-1:0]   paddr,
  input  logic [bel_pkg::PDATA_W-1:0]   pwdata,
  output logic [bel_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bel_pkg::*;

  logic                  accept;
  logic                  tick, read;
  logic [PERIOD_W-1:0]   init_period;
  logic [PERIOD_W-1:0]   period, period_next;
  bel_btn_status_t       st [NUM_BUTTONS];
  reg_index_t            reg_idx;
  bel_out_t              result;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  assign tick     = accept & (in_data.req_type == REQ_TICK);
  assign read     = accept & (in_data.req_type == REQ_READ);

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[PADDR_W-1:2]);
  assign prdata  = (reg_idx == REG_INITIAL_REPEAT_PERIOD) ?
                   PDATA_W'(init_period) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_period <= DEFAULT_PERIOD;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == REG_INITIAL_REPEAT_PERIOD) begin
      init_period <= pwdata[PERIOD_W-1:0];
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    bel_btn u_btn (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .read   (read),
      .level  (in_data.button_levels[i]),
      .period (period),
      .status (st[i])
    );
  end

  // period shortening and restore on a read
  always_comb begin
    period_next = period;
    if (read) begin
      if (st[PERIOD_BTN].rpt && period > MIN_PERIOD) begin
        period_next = period - PERIOD_W'(1);
      end
      if (st[PERIOD_BTN].released) begin
        period_next = init_period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= DEFAULT_PERIOD;
    end else begin
      period <= period_next;
    end
  end

  always_comb begin
    result.b1_pressed         = st[0].pressed;
    result.b1_released        = st[0].released;
    result.b1_autorep         = st[0].rpt;
    result.b2_pressed         = st[1].pressed;
    result.b2_released        = st[1].released;
    result.b2_autorep         = st[1].rpt;
    result.b3_pressed         = st[2].pressed;
    result.b3_released        = st[2].released;
    result.b3_autorep         = st[2].rpt;
    result.one_and_three_held = st[0].pressed & ~st[0].released &
                                st[2].pressed & ~st[2].released;
    result.one_and_three_free = ~st[0].held & ~st[2].held;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_read_gives_transfer: assert property (@(posedge clk) disable iff (rst)
    read |=> out_valid)
    else $error("read did not produce a result");

  a_tick_no_result: assert property (@(posedge clk) disable iff (rst)
    (tick && !out_valid) |=> !out_valid)
    else $error("tick produced a result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting result changed or dropped");

  a_period_step: assert property (@(posedge clk) disable iff (rst)
    (read && !st[PERIOD_BTN].released) |=>
      (period == $past(period) || period == $past(period) - PERIOD_W'(1)))
    else $error("period changed by more than one step");
`endif

endmodule
